>>> rtl/core/follow_velocity_controller_macros.svh
// assertion macros for the follow velocity controller
// no dependencies
`ifndef FOLLOW_VELOCITY_CONTROLLER_MACROS_SVH
`define FOLLOW_VELOCITY_CONTROLLER_MACROS_SVH
`ifndef ASSERT_OFF
`define FVC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`else
`define FVC_ASSERT(label, clk, rst_n, prop, msg)
`endif
`ifndef ASSERT_OFF
`define FVC_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FVC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> rtl/core/fvc_pkg.sv
// shared types and constants for the follow velocity controller
// no dependencies
package fvc_pkg;
  localparam int unsigned PosW = 24;
  localparam int unsigned AngW = 15;
  localparam int unsigned Phw = 2;
  localparam logic signed [15:0] PiQ12 = 16'sd12868;
  localparam logic signed [15:0] TwoPiQ12 = 16'sd25736;
  localparam logic signed [25:0] HalfPiQ20 = 26'sd1647099;
  localparam logic signed [10:0] VzLim = 11'sd512;
  localparam logic signed [10:0] VzSearchLim = 11'sd410;
  localparam logic signed [14:0] SearchYaw = 15'sd614;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TAKEOFF = 2'd1,
    PH_SEARCH = 2'd2,
    PH_FOLLOW = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    REP_NONE = 2'd0,
    REP_SEEN = 2'd1,
    REP_LOST = 2'd2,
    REP_RSVD = 2'd3
  } report_e;

  typedef enum logic [2:0] {
    REG_FOLLOW_DIST = 3'd0,
    REG_HOLD_HEIGHT = 3'd1,
    REG_CLIMB_HEIGHT = 3'd2,
    REG_FWD_LIMIT = 3'd3,
    REG_TURN_LIMIT = 3'd4,
    REG_RANGE_GAIN = 3'd5,
    REG_HEIGHT_GAIN = 3'd6,
    REG_BEARING_GAIN = 3'd7
  } reg_e;

  typedef struct packed {
    logic [15:0] follow_distance;
    logic [15:0] hold_height;
    logic [15:0] climb_height;
    logic [13:0] forward_speed_limit;
    logic [13:0] turn_rate_limit;
    logic [11:0] range_gain;
    logic [11:0] height_gain;
    logic [11:0] bearing_gain;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic latch;     // take input item into state
    logic start;     // begin sqrt and cordic
    logic step;      // one iteration
    logic law_vz;    // form vertical term
    logic law_fwd;   // form forward and yaw terms
    logic smooth;    // smoother and output
    logic expire;    // detection timeout
  } cmd_t;

  typedef struct packed {
    logic climb_done;
    logic detected;
    logic pose_seen;
    logic target_held;
  } stat_t;

  function automatic logic [23:0] atan_q20(input logic [4:0] i);
    case (i)
      5'd0: atan_q20 = 24'd823550;
      5'd1: atan_q20 = 24'd486170;
      5'd2: atan_q20 = 24'd256879;
      5'd3: atan_q20 = 24'd130396;
      5'd4: atan_q20 = 24'd65451;
      5'd5: atan_q20 = 24'd32757;
      5'd6: atan_q20 = 24'd16383;
      5'd7: atan_q20 = 24'd8192;
      5'd8: atan_q20 = 24'd4096;
      5'd9: atan_q20 = 24'd2048;
      5'd10: atan_q20 = 24'd1024;
      5'd11: atan_q20 = 24'd512;
      5'd12: atan_q20 = 24'd256;
      5'd13: atan_q20 = 24'd128;
      5'd14: atan_q20 = 24'd64;
      5'd15: atan_q20 = 24'd32;
      5'd16: atan_q20 = 24'd16;
      5'd17: atan_q20 = 24'd8;
      5'd18: atan_q20 = 24'd4;
      5'd19: atan_q20 = 24'd2;
      5'd20: atan_q20 = 24'd1;
      5'd21: atan_q20 = 24'd1;
      default: atan_q20 = 24'd0;
    endcase
  endfunction
endpackage

>>> rtl/core/follow_velocity_controller.sv
// top level of the follow velocity controller: config registers, controller, datapath
// depends on fvc_pkg, fvc_ctrl, fvc_datapath
// One item is one control tick. It is taken when in_valid is high and in_stall low, and the
// result then appears on out_valid. in_stall stays high until the result is accepted, so the
// next item is not taken before then, and a tick is held as long as out_stall is high. Each
// tick runs 25 shared iterations that compute the square root and the cordic arctangent side
// by side.
module follow_velocity_controller #(
  parameter int unsigned TIMEOUT_TICKS = 250,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               flying_enabled_i,
  input  logic               pose_update_i,
  input  logic signed [23:0] own_x_i,
  input  logic signed [23:0] own_y_i,
  input  logic signed [23:0] own_z_i,
  input  logic signed [14:0] own_heading_i,
  input  logic               target_update_i,
  input  logic signed [23:0] goal_x_i,
  input  logic signed [23:0] goal_y_i,
  input  logic [1:0]         detection_report_i,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] forward_velocity_o,
  output logic signed [10:0] vertical_velocity_o,
  output logic signed [14:0] turn_rate_o,
  output logic [1:0]         phase_o,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import fvc_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  stat_t stat;
  phase_e ph;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{follow_distance: 16'd2048, hold_height: 16'd2048, climb_height: 16'd2048,
                 forward_speed_limit: 14'd2048, turn_rate_limit: 14'd4096,
                 range_gain: 12'd128, height_gain: 12'd128, bearing_gain: 12'd768};
    end else if (cfg_valid) begin
      case (reg_e'(cfg_index_i))
        REG_FOLLOW_DIST: cfg_q.follow_distance <= cfg_data_i;
        REG_HOLD_HEIGHT: cfg_q.hold_height <= cfg_data_i;
        REG_CLIMB_HEIGHT: cfg_q.climb_height <= cfg_data_i;
        REG_FWD_LIMIT: cfg_q.forward_speed_limit <= cfg_data_i[13:0];
        REG_TURN_LIMIT: cfg_q.turn_rate_limit <= cfg_data_i[13:0];
        REG_RANGE_GAIN: cfg_q.range_gain <= cfg_data_i[11:0];
        REG_HEIGHT_GAIN: cfg_q.height_gain <= cfg_data_i[11:0];
        REG_BEARING_GAIN: cfg_q.bearing_gain <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  fvc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .flying_enabled_i, .in_stall, .out_valid, .out_stall,
    .stat_i(stat), .cmd_o(cmd), .phase_o(ph)
  );

  fvc_datapath #(.TimeoutTicks(TIMEOUT_TICKS), .CordicSteps(CORDIC_STEPS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .cfg_i(cfg_q),
    .flying_enabled_i, .pose_update_i, .own_x_i, .own_y_i, .own_z_i, .own_heading_i,
    .target_update_i, .goal_x_i, .goal_y_i, .detection_report_i,
    .phase_i(ph), .stat_o(stat),
    .forward_velocity_o, .vertical_velocity_o, .turn_rate_o, .phase_o
  );
endmodule

>>> rtl/core/fvc_datapath.sv
// datapath: held state, sqrt and cordic iterations, control laws, smoother
// depends on fvc_pkg
module fvc_datapath #(
  parameter int unsigned TimeoutTicks = 250,
  parameter int unsigned CordicSteps = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fvc_pkg::cmd_t       cmd_i,
  input  fvc_pkg::cfg_t       cfg_i,
  input  logic                flying_enabled_i,
  input  logic                pose_update_i,
  input  logic signed [23:0]  own_x_i,
  input  logic signed [23:0]  own_y_i,
  input  logic signed [23:0]  own_z_i,
  input  logic signed [14:0]  own_heading_i,
  input  logic                target_update_i,
  input  logic signed [23:0]  goal_x_i,
  input  logic signed [23:0]  goal_y_i,
  input  logic [1:0]          detection_report_i,
  input  fvc_pkg::phase_e     phase_i,
  output fvc_pkg::stat_t      stat_o,
  output logic signed [14:0]  forward_velocity_o,
  output logic signed [10:0]  vertical_velocity_o,
  output logic signed [14:0]  turn_rate_o,
  output logic [1:0]          phase_o
);
  import fvc_pkg::*;

  localparam int unsigned Steps = (CordicSteps < 24) ? CordicSteps : 24;

  logic pose_seen_q, target_held_q, detected_q, climb_done_q;
  logic signed [23:0] held_x_q, held_y_q, held_z_q, gx_q, gy_q;
  logic signed [14:0] held_hd_q;
  logic [15:0] ticks_q;
  logic signed [14:0] sm_fwd_q, fwd_q, yaw_q, out_fwd_q, out_yaw_q;
  logic signed [10:0] sm_vz_q, vz_q, out_vz_q;
  logic [1:0] out_ph_q;

  // sqrt
  logic [49:0] rem_q;
  logic [24:0] root_q;
  logic [4:0] sq_i_q;
  // cordic, Q.20 angle
  logic signed [27:0] cx_q, cy_q;
  logic signed [26:0] cz_q;
  logic [4:0] ck_q;
  logic czero_q;

  logic signed [24:0] dx, dy;
  logic signed [49:0] dxx, dyy;
  logic signed [27:0] xs, ys;
  logic signed [26:0] at;

  assign dx = 25'(gx_q) - 25'(held_x_q);
  assign dy = 25'(gy_q) - 25'(held_y_q);
  assign dxx = dx * dx;
  assign dyy = dy * dy;
  assign xs = cx_q >>> ck_q;
  assign ys = cy_q >>> ck_q;
  assign at = 27'(signed'({1'b0, atan_q20(ck_q)}));

  // laws
  logic signed [39:0] pz;
  logic signed [31:0] qz;
  logic signed [10:0] vlim;
  logic signed [26:0] err;
  logic signed [39:0] pf;
  logic signed [31:0] qf;
  logic signed [17:0] bq, berr, bw;
  logic signed [30:0] pb;
  logic signed [22:0] qb;
  logic signed [14:0] flim, tlim;

  always_comb begin
    logic signed [25:0] dzw;
    dzw = (phase_i == PH_TAKEOFF) ? (26'(signed'({1'b0, cfg_i.climb_height})) - 26'(held_z_q))
                                  : (26'(signed'({1'b0, cfg_i.hold_height})) - 26'(held_z_q));
    pz = 40'(dzw) * 40'(signed'({1'b0, cfg_i.height_gain}));
    qz = 32'(pz >>> 8);
    vlim = (phase_i == PH_SEARCH) ? VzSearchLim : VzLim;
    err = 27'(signed'({1'b0, root_q[24:0]})) - 27'(signed'({1'b0, cfg_i.follow_distance}));
    pf = 40'(err) * 40'(signed'({1'b0, cfg_i.range_gain}));
    qf = 32'(pf >>> 8);
    bq = czero_q ? 18'sd0 : 18'((cz_q + 27'sd128) >>> 8);
    berr = bq - 18'(held_hd_q);
    bw = berr;
    if (berr > 18'(PiQ12)) bw = berr - 18'(TwoPiQ12);
    else if (berr < -18'(PiQ12)) bw = berr + 18'(TwoPiQ12);
    pb = 31'(bw) * 31'(signed'({1'b0, cfg_i.bearing_gain}));
    qb = 23'(pb >>> 8);
    flim = 15'(signed'({1'b0, cfg_i.forward_speed_limit}));
    tlim = 15'(signed'({1'b0, cfg_i.turn_rate_limit}));
  end

  // divide by five toward zero by reciprocal multiply, exact for magnitudes below 2^18
  function automatic logic signed [17:0] div5(input logic signed [17:0] n);
    logic [17:0] mag;
    logic [33:0] prod;
    logic signed [17:0] q;
    mag = n[17] ? unsigned'(-n) : unsigned'(n);
    prod = 34'(mag) * 34'd52429;
    q = signed'({2'b00, prod[33:18]});
    div5 = n[17] ? -q : q;
  endfunction

  logic signed [17:0] s4f, s4v;
  logic signed [17:0] nf, nv;
  assign s4f = 18'(sm_fwd_q) * 18'sd4 + 18'(fwd_q);
  assign s4v = 18'(sm_vz_q) * 18'sd4 + 18'(vz_q);
  assign nf = div5(s4f);
  assign nv = div5(s4v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_seen_q <= 1'b0;
      target_held_q <= 1'b0;
      detected_q <= 1'b0;
      climb_done_q <= 1'b0;
      ticks_q <= '0;
      sm_fwd_q <= '0;
      sm_vz_q <= '0;
      held_x_q <= '0;
      held_y_q <= '0;
      held_z_q <= '0;
      held_hd_q <= '0;
      gx_q <= '0;
      gy_q <= '0;
    end else begin
      if (cmd_i.latch) begin
        if (pose_update_i) begin
          held_x_q <= own_x_i;
          held_y_q <= own_y_i;
          held_z_q <= own_z_i;
          held_hd_q <= own_heading_i;
          pose_seen_q <= 1'b1;
        end
        if (target_update_i) begin
          gx_q <= goal_x_i;
          gy_q <= goal_y_i;
          target_held_q <= 1'b1;
        end
        if (detection_report_i == REP_SEEN) begin
          detected_q <= 1'b1;
          ticks_q <= '0;
        end else begin
          if (ticks_q != 16'hffff) ticks_q <= ticks_q + 16'd1;
          if (detection_report_i == REP_LOST) detected_q <= 1'b0;
        end
      end
      if (cmd_i.law_vz && phase_i == PH_TAKEOFF && pose_seen_q
          && held_z_q >= 24'(signed'({1'b0, cfg_i.climb_height})))
        climb_done_q <= 1'b1;
      if (cmd_i.smooth) begin
        sm_fwd_q <= nf[14:0];
        sm_vz_q <= nv[10:0];
      end
      if (cmd_i.expire && detected_q && ticks_q >= 16'(TimeoutTicks)) begin
        detected_q <= 1'b0;
        target_held_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rem_q <= 50'(dxx) + 50'(dyy);
      root_q <= '0;
      sq_i_q <= 5'd24;
      czero_q <= (dx == 0) && (dy == 0);
      ck_q <= '0;
      if (dx < 0) begin
        if (dy >= 0) begin
          cx_q <= 28'(dy); cy_q <= -28'(dx); cz_q <= 27'(HalfPiQ20);
        end else begin
          cx_q <= -28'(dy); cy_q <= 28'(dx); cz_q <= -27'(HalfPiQ20);
        end
      end else begin
        cx_q <= 28'(dx); cy_q <= 28'(dy); cz_q <= '0;
      end
    end
    if (cmd_i.step) begin
      // one result bit of the floor square root per step
      if (rem_q >= ({25'd0, root_q} << (sq_i_q + 5'd1)) + (50'd1 << {sq_i_q, 1'b0})) begin
        rem_q <= rem_q - (({25'd0, root_q} << (sq_i_q + 5'd1)) + (50'd1 << {sq_i_q, 1'b0}));
        root_q <= root_q | (25'd1 << sq_i_q);
      end
      if (sq_i_q != 5'd0) sq_i_q <= sq_i_q - 5'd1;
      if (32'(ck_q) < Steps) begin
        if (cy_q > 0) begin
          cx_q <= cx_q + ys; cy_q <= cy_q - xs; cz_q <= cz_q + at;
        end else begin
          cx_q <= cx_q - ys; cy_q <= cy_q + xs; cz_q <= cz_q - at;
        end
        ck_q <= ck_q + 5'd1;
      end
    end
    if (cmd_i.latch) begin
      fwd_q <= '0; vz_q <= '0; yaw_q <= '0;
    end
    if (cmd_i.law_vz && pose_seen_q && phase_i != PH_IDLE
        && !(phase_i == PH_FOLLOW && !target_held_q)) begin
      vz_q <= (qz > 32'(vlim)) ? vlim : (qz < -32'(vlim)) ? -vlim : 11'(qz);
      if (phase_i == PH_SEARCH) yaw_q <= SearchYaw;
    end
    if (cmd_i.law_fwd && pose_seen_q && target_held_q && phase_i == PH_FOLLOW) begin
      fwd_q <= (qf > 32'(flim)) ? flim : (qf < -32'(flim)) ? -flim : 15'(qf);
      yaw_q <= (qb > 23'(tlim)) ? tlim : (qb < -23'(tlim)) ? -tlim : 15'(qb);
    end
    if (cmd_i.smooth) begin
      out_fwd_q <= nf[14:0];
      out_vz_q <= nv[10:0];
      out_yaw_q <= yaw_q;
      out_ph_q <= phase_i;
    end
  end

  assign stat_o = '{climb_done: climb_done_q, detected: detected_q,
                    pose_seen: pose_seen_q, target_held: target_held_q};
  assign forward_velocity_o = out_fwd_q;
  assign vertical_velocity_o = out_vz_q;
  assign turn_rate_o = out_yaw_q;
  assign phase_o = out_ph_q;

  logic unused;
  assign unused = ^{flying_enabled_i};
endmodule

>>> rtl/core/fvc_ctrl.sv
// controller: sequences one tick through latch, iterations, laws and smoother
// depends on fvc_pkg and the macro header
`include "follow_velocity_controller_macros.svh"
module fvc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid,
  input  logic            flying_enabled_i,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  fvc_pkg::stat_t  stat_i,
  output fvc_pkg::cmd_t   cmd_o,
  output fvc_pkg::phase_e phase_o
);
  import fvc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_ITER, S_LAW, S_SMOOTH, S_OUT
  } state_e;

  state_e state_q;
  logic [4:0] cnt_q;
  logic fly_q;
  phase_e ph_q;
  logic accept;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_q != S_IDLE);
  assign out_valid = (state_q == S_OUT);
  assign phase_o = ph_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.latch = accept;
    cmd_o.start = (state_q == S_START);
    cmd_o.step = (state_q == S_ITER);
    cmd_o.law_vz = (state_q == S_LAW);
    cmd_o.law_fwd = (state_q == S_LAW);
    cmd_o.smooth = (state_q == S_SMOOTH);
    cmd_o.expire = (state_q == S_SMOOTH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      fly_q <= 1'b0;
      ph_q <= PH_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            fly_q <= flying_enabled_i;
            state_q <= S_START;
          end
        end
        S_START: begin
          // phase uses state after latching
          if (!fly_q) ph_q <= PH_IDLE;
          else if (!stat_i.climb_done) ph_q <= PH_TAKEOFF;
          else if (!stat_i.detected) ph_q <= PH_SEARCH;
          else ph_q <= PH_FOLLOW;
          cnt_q <= '0;
          state_q <= S_ITER;
        end
        S_ITER: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd24) state_q <= S_LAW;
        end
        S_LAW: state_q <= S_SMOOTH;
        S_SMOOTH: state_q <= S_OUT;
        S_OUT: if (!out_stall) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `FVC_ASSERT(a_no_accept_busy, clk_i, rst_ni, (state_q != S_IDLE) |-> !accept, "accept while busy")
  `FVC_ASSERT(a_out_holds, clk_i, rst_ni, (out_valid && out_stall) |=> out_valid, "result dropped")
  `FVC_ASSERT(a_iter_bound, clk_i, rst_ni, (state_q == S_ITER) |-> (cnt_q <= 5'd24), "iteration overrun")
endmodule
